// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the YAML line splitter RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define YLS_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define YLS_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
	else $error("assertion failed");
`else
`define YLS_ASSERT(name, clk, rst_n, prop)
`define YLS_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// ===== rtl/core/yls_pkg.sv =====
// Shared types and constants for the YAML line splitter.
// Depends on nothing.
package yls_pkg;

	localparam int unsigned MAX_INDENT_DEF = 255;
	localparam int unsigned INDENT_W       = 8;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		CL_INDENT = 3'd0,
		CL_MARKER = 3'd1,
		CL_KEY    = 3'd2,
		CL_COLON  = 3'd3,
		CL_GAP    = 3'd4,
		CL_VALUE  = 3'd5,
		CL_TERM   = 3'd6
	} cls_t;

	typedef struct packed {
		cls_t                cls;
		logic [INDENT_W-1:0] indent;
		logic                list_item;
		logic                has_key;
		logic                has_value;
	} res_t;

endpackage

// ===== rtl/core/yls_in_stage.sv =====
// Input register of the YAML line splitter.
// Depends on nothing; holds one transaction until the parser takes it.
module yls_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_byte,
	input  logic       end_of_line,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] char_s1,
	output logic       eol_s1
);

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= char_byte;
			eol_s1  <= end_of_line;
		end
	end

endmodule

// ===== rtl/core/yls_parser.sv =====
// Line state and byte classification of the YAML line splitter.
// Depends on yls_pkg and assert_macros.svh.
`include "assert_macros.svh"
module yls_parser #(
	parameter int unsigned MAX_INDENT = yls_pkg::MAX_INDENT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        char_s1,
	input  logic              eol_s1,
	output yls_pkg::res_t     res
);

	localparam int unsigned CAP_I = (MAX_INDENT < 255) ? MAX_INDENT : 255;
	localparam logic [yls_pkg::INDENT_W-1:0] CAP = yls_pkg::INDENT_W'(CAP_I);

	typedef enum logic [2:0] {
		PH_INDENT  = 3'd0,
		PH_MARKER  = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_GAP     = 3'd3,
		PH_VALUE   = 3'd4
	} phase_t;

	phase_t                      phase_q, phase_n;
	logic [yls_pkg::INDENT_W-1:0] indent_q, indent_n;
	logic                        list_q, list_n;
	logic                        sq_q, sq_n;
	logic                        dq_q, dq_n;
	logic [7:0]                  prev_q, prev_n;
	logic                        start_q, start_n;
	logic                        key_q, key_n;
	logic                        value_q, value_n;
	logic                        pl;
	yls_pkg::cls_t               cls;
	logic                        line_clean;

	always_comb begin
		phase_n  = phase_q;
		indent_n = indent_q;
		list_n   = list_q;
		sq_n     = sq_q;
		dq_n     = dq_q;
		start_n  = start_q;
		key_n    = key_q;
		value_n  = value_q;
		prev_n   = char_s1;
		cls      = yls_pkg::CL_KEY;
		pl       = 1'b0;
		unique case (phase_q)
			PH_INDENT: begin
				if (char_s1 == yls_pkg::CH_SPACE) begin
					if (indent_q < CAP)
						indent_n = indent_q + 1'b1;
					cls = yls_pkg::CL_INDENT;
				end else if (char_s1 == yls_pkg::CH_DASH) begin
					list_n  = 1'b1;
					phase_n = PH_MARKER;
					cls     = yls_pkg::CL_MARKER;
				end else begin
					phase_n = PH_PAYLOAD;
					pl      = 1'b1;
				end
			end
			PH_MARKER: begin
				if (char_s1 == yls_pkg::CH_SPACE) begin
					cls = yls_pkg::CL_MARKER;
				end else begin
					phase_n = PH_PAYLOAD;
					pl      = 1'b1;
				end
			end
			PH_PAYLOAD: pl = 1'b1;
			PH_GAP: begin
				if (char_s1 == yls_pkg::CH_SPACE) begin
					cls = yls_pkg::CL_GAP;
				end else begin
					value_n = 1'b1;
					phase_n = PH_VALUE;
					cls     = yls_pkg::CL_VALUE;
				end
			end
			PH_VALUE: cls = yls_pkg::CL_VALUE;
			default: begin
				phase_n = PH_VALUE;
				cls     = yls_pkg::CL_VALUE;
			end
		endcase
		if (pl) begin
			start_n = 1'b0;
			if (char_s1 == yls_pkg::CH_SQUOTE && !dq_q) begin
				if (!(!start_q && prev_q == yls_pkg::CH_SQUOTE))
					sq_n = !sq_q;
			end else if (char_s1 == yls_pkg::CH_DQUOTE && !sq_q) begin
				if (!(!start_q && prev_q == yls_pkg::CH_BSLASH))
					dq_n = !dq_q;
			end else if (!sq_q && !dq_q && char_s1 == yls_pkg::CH_COLON) begin
				key_n   = 1'b1;
				phase_n = PH_GAP;
				cls     = yls_pkg::CL_COLON;
			end
		end
		res = '{cls: cls, indent: '0, list_item: 1'b0, has_key: 1'b0, has_value: 1'b0};
		if (eol_s1) begin
			res = '{cls: yls_pkg::CL_TERM, indent: indent_q, list_item: list_q,
				has_key: key_q, has_value: value_q};
			phase_n  = PH_INDENT;
			indent_n = '0;
			list_n   = 1'b0;
			sq_n     = 1'b0;
			dq_n     = 1'b0;
			prev_n   = '0;
			start_n  = 1'b1;
			key_n    = 1'b0;
			value_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_INDENT;
			indent_q <= '0;
			list_q   <= 1'b0;
			sq_q     <= 1'b0;
			dq_q     <= 1'b0;
			prev_q   <= '0;
			start_q  <= 1'b1;
			key_q    <= 1'b0;
			value_q  <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_n;
			indent_q <= indent_n;
			list_q   <= list_n;
			sq_q     <= sq_n;
			dq_q     <= dq_n;
			prev_q   <= prev_n;
			start_q  <= start_n;
			key_q    <= key_n;
			value_q  <= value_n;
		end
	end

	assign line_clean = !key_q && !value_q && !list_q && start_q;

	// line state is clean while still in the indent
	`YLS_ASSERT(a_indent_clean, clk, arst_n, (phase_q == PH_INDENT) |-> line_clean)
	`YLS_ASSERT(a_value_needs_key, clk, arst_n, value_q |-> key_q)
	`YLS_ASSERT(a_quotes_exclusive, clk, arst_n, !(sq_q && dq_q))
	`YLS_ASSERT(a_indent_cap, clk, arst_n, indent_q <= CAP)

endmodule

// ===== rtl/core/yls_out_stage.sv =====
// Result register of the YAML line splitter.
// Depends on yls_pkg.
module yls_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  yls_pkg::res_t                res,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [2:0]                   byte_class,
	output logic [yls_pkg::INDENT_W-1:0] indent_count,
	output logic                         list_item,
	output logic                         has_key,
	output logic                         has_value
);

	yls_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= load || (out_valid && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	assign byte_class   = res_q.cls;
	assign indent_count = res_q.indent;
	assign list_item    = res_q.list_item;
	assign has_key      = res_q.has_key;
	assign has_value    = res_q.has_value;

endmodule

// ===== rtl/core/yaml_line_splitter.sv =====
// YAML line splitter, top level.
// Depends on yls_pkg, yls_in_stage, yls_parser and yls_out_stage.
//
// Input channel: in_valid / in_stall with char_byte and end_of_line. Bytes of
// one line arrive in order; a transaction with end_of_line high closes it.
// Output channel: out_valid / out_stall, one result per input transaction:
// byte_class for each byte, and on the terminator the indent count, list
// flag, key flag and value flag of the line (these are zero on byte results).
// Path: each transaction passes through the input register and then the
// result register, which is loaded when the parser takes the transaction.
// Throughput is one transaction per cycle while out_stall holds no result;
// the line state lives in single registers updated by one level of
// classification logic, so consecutive bytes never wait on each other.
// When out_stall holds a result, the input register keeps one more
// transaction and in_stall rises only once both registers are full.
// Reset clears both valid flags and returns the line state to the start of
// a line with zero indent.
module yaml_line_splitter #(
	parameter int unsigned MAX_INDENT = yls_pkg::MAX_INDENT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   char_byte,
	input  logic                         end_of_line,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   byte_class,
	output logic [yls_pkg::INDENT_W-1:0] indent_count,
	output logic                         list_item,
	output logic                         has_key,
	output logic                         has_value
);

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          eol_s1;
	logic          take;
	logic          fire;
	yls_pkg::res_t res;

	assign take = !(out_valid && out_stall);
	assign fire = valid_s1 && take;

	yls_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_byte   (char_byte),
		.end_of_line (end_of_line),
		.take        (take),
		.valid_s1    (valid_s1),
		.char_s1     (char_s1),
		.eol_s1      (eol_s1)
	);

	yls_parser #(
		.MAX_INDENT (MAX_INDENT)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.char_s1 (char_s1),
		.eol_s1  (eol_s1),
		.res     (res)
	);

	yls_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire),
		.res          (res),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.byte_class   (byte_class),
		.indent_count (indent_count),
		.list_item    (list_item),
		.has_key      (has_key),
		.has_value    (has_value)
	);

endmodule

// ===== tb/sv/yls_checker.sv =====
// Checker for the YAML line splitter: watches both channels, predicts each result
// from accepted input transactions and compares it field by field.
// Depends on yls_pkg.
module yls_checker #(
	parameter int unsigned MAX_INDENT = yls_pkg::MAX_INDENT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] char_byte,
	input  logic       end_of_line,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] byte_class,
	input  logic [7:0] indent_count,
	input  logic       list_item,
	input  logic       has_key,
	input  logic       has_value,
	output int         fail_count,
	output int         outstanding
);

	localparam int unsigned INDENT_CAP = (MAX_INDENT < 255) ? MAX_INDENT : 255;

	typedef enum logic [2:0] {
		PH_INDENT,
		PH_MARKER,
		PH_PAYLOAD,
		PH_GAP,
		PH_VALUE
	} line_phase_t;

	line_phase_t phase;
	logic [7:0]  indent_total;
	logic        list_flag;
	logic        in_squote;
	logic        in_dquote;
	logic [7:0]  prev_byte;
	logic        payload_start;
	logic        key_found;
	logic        value_found;

	yls_pkg::res_t expected_results[$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	function automatic void restart_line();
		phase         = PH_INDENT;
		indent_total  = '0;
		list_flag     = 1'b0;
		in_squote     = 1'b0;
		in_dquote     = 1'b0;
		prev_byte     = '0;
		payload_start = 1'b1;
		key_found     = 1'b0;
		value_found   = 1'b0;
	endfunction

	function automatic yls_pkg::cls_t classify_payload(logic [7:0] c);
		logic first;
		first         = payload_start;
		payload_start = 1'b0;
		if (c == yls_pkg::CH_SQUOTE && !in_dquote) begin
			if (!(!first && prev_byte == yls_pkg::CH_SQUOTE))
				in_squote = !in_squote;
		end else if (c == yls_pkg::CH_DQUOTE && !in_squote) begin
			if (!(!first && prev_byte == yls_pkg::CH_BSLASH))
				in_dquote = !in_dquote;
		end else if (!in_squote && !in_dquote && c == yls_pkg::CH_COLON) begin
			key_found = 1'b1;
			phase     = PH_GAP;
			return yls_pkg::CL_COLON;
		end
		return yls_pkg::CL_KEY;
	endfunction

	function automatic yls_pkg::res_t split_step(logic [7:0] c, logic eol);
		yls_pkg::res_t r;
		r = '0;
		if (eol) begin
			r.cls       = yls_pkg::CL_TERM;
			r.indent    = indent_total;
			r.list_item = list_flag;
			r.has_key   = key_found;
			r.has_value = value_found;
			restart_line();
			return r;
		end
		case (phase)
			PH_INDENT: begin
				if (c == yls_pkg::CH_SPACE) begin
					if (indent_total < INDENT_CAP)
						indent_total = indent_total + 8'd1;
					r.cls = yls_pkg::CL_INDENT;
				end else if (c == yls_pkg::CH_DASH) begin
					list_flag = 1'b1;
					phase     = PH_MARKER;
					r.cls     = yls_pkg::CL_MARKER;
				end else begin
					phase = PH_PAYLOAD;
					r.cls = classify_payload(c);
				end
			end
			PH_MARKER: begin
				if (c == yls_pkg::CH_SPACE) begin
					r.cls = yls_pkg::CL_MARKER;
				end else begin
					phase = PH_PAYLOAD;
					r.cls = classify_payload(c);
				end
			end
			PH_PAYLOAD: r.cls = classify_payload(c);
			PH_GAP: begin
				if (c == yls_pkg::CH_SPACE) begin
					r.cls = yls_pkg::CL_GAP;
				end else begin
					value_found = 1'b1;
					phase       = PH_VALUE;
					r.cls       = yls_pkg::CL_VALUE;
				end
			end
			default: begin
				phase = PH_VALUE;
				r.cls = yls_pkg::CL_VALUE;
			end
		endcase
		prev_byte = c;
		return r;
	endfunction

	task automatic note_failure(string msg);
		if (fail_count < 10)
			$display("[%0t] %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		yls_pkg::res_t want;
		if (!arst_n) begin
			restart_line();
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(split_step(char_byte, end_of_line));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					note_failure($sformatf("unexpected result: class %0d indent %0d flags %b%b%b",
						byte_class, indent_count, list_item, has_key, has_value));
				end else begin
					want = expected_results.pop_front();
					if (byte_class !== want.cls || indent_count !== want.indent ||
						list_item !== want.list_item || has_key !== want.has_key ||
						has_value !== want.has_value)
						note_failure($sformatf({"mismatch: class exp %0d got %0d, indent exp %0d ",
							"got %0d, list/key/value exp %b%b%b got %b%b%b"},
							want.cls, byte_class, want.indent, indent_count,
							want.list_item, want.has_key, want.has_value,
							list_item, has_key, has_value));
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the YAML line splitter: clock, reset, line stimulus and verdict.
// Depends on yls_pkg, yaml_line_splitter and yls_checker.
module tb_top;

	localparam int ITEM_TARGET = 1550;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_byte;
	logic       end_of_line;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] byte_class;
	logic [7:0] indent_count;
	logic       list_item;
	logic       has_key;
	logic       has_value;
	int         fail_count;
	int         outstanding;
	int         sent;
	logic       calm;

	yaml_line_splitter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_byte(char_byte), .end_of_line(end_of_line),
		.out_valid(out_valid), .out_stall(out_stall),
		.byte_class(byte_class), .indent_count(indent_count),
		.list_item(list_item), .has_key(has_key), .has_value(has_value)
	);

	yls_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.char_byte(char_byte), .end_of_line(end_of_line),
		.out_valid(out_valid), .out_stall(out_stall),
		.byte_class(byte_class), .indent_count(indent_count),
		.list_item(list_item), .has_key(has_key), .has_value(has_value),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 35);

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(logic [7:0] b, logic eol);
		int gap;
		gap = (!calm && $urandom_range(0, 99) < 35) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			in_valid    <= 1'b0;
			char_byte   <= 8'($urandom_range(0, 255));
			end_of_line <= 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		char_byte   <= b;
		end_of_line <= eol;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_line(logic [7:0] text[$]);
		foreach (text[i])
			send_item(text[i], 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 11))
			0:       return yls_pkg::CH_SQUOTE;
			1:       return yls_pkg::CH_DQUOTE;
			2:       return yls_pkg::CH_BSLASH;
			3:       return yls_pkg::CH_COLON;
			4:       return yls_pkg::CH_SPACE;
			5:       return yls_pkg::CH_DASH;
			6:       return 8'($urandom_range(0, 255));
			default: return 8'("a" + $urandom_range(0, 25));
		endcase
	endfunction

	task automatic send_random_line();
		logic [7:0] q[$];
		logic [7:0] qc;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(0, 10))
				q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 6))
				q.push_back(yls_pkg::CH_SPACE);
			if ($urandom_range(0, 1)) begin
				q.push_back(yls_pkg::CH_DASH);
				repeat ($urandom_range(0, 2))
					q.push_back(yls_pkg::CH_SPACE);
			end
			if ($urandom_range(0, 99) < 30) begin
				qc = $urandom_range(0, 1) ? yls_pkg::CH_SQUOTE : yls_pkg::CH_DQUOTE;
				q.push_back(qc);
				repeat ($urandom_range(0, 5))
					q.push_back(pick_char());
				q.push_back(qc);
			end
			repeat ($urandom_range(0, 6))
				q.push_back(pick_char());
			if ($urandom_range(0, 99) < 70) begin
				q.push_back(yls_pkg::CH_COLON);
				repeat ($urandom_range(0, 3))
					q.push_back(yls_pkg::CH_SPACE);
				repeat ($urandom_range(0, 5))
					q.push_back(pick_char());
			end
		end
		send_line(q);
	endtask

	initial begin
		logic [7:0] q[$];
		logic       drained;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		char_byte   = 8'h00;
		end_of_line = 1'b0;
		out_stall   = 1'b0;
		calm        = 1'b0;
		drained     = 1'b0;
		sent        = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed lines
		q = {};
		send_line(q);
		q = {8'h00};
		send_line(q);
		q = {yls_pkg::CH_SPACE, yls_pkg::CH_SPACE, yls_pkg::CH_DASH, yls_pkg::CH_SPACE,
			yls_pkg::CH_SPACE, "k", yls_pkg::CH_COLON, yls_pkg::CH_SPACE,
			yls_pkg::CH_SPACE, "v"};
		send_line(q);
		q = {yls_pkg::CH_COLON, 8'hFF};
		send_line(q);
		q = {yls_pkg::CH_DQUOTE, yls_pkg::CH_BSLASH, yls_pkg::CH_DQUOTE, yls_pkg::CH_COLON,
			yls_pkg::CH_DQUOTE};
		send_line(q);

		// indent past saturation
		q = {};
		repeat (256 + $urandom_range(0, 6))
			q.push_back(yls_pkg::CH_SPACE);
		q.push_back(yls_pkg::CH_SQUOTE);
		q.push_back(yls_pkg::CH_SQUOTE);
		q.push_back(yls_pkg::CH_COLON);
		q.push_back("x");
		send_line(q);

		while (sent < ITEM_TARGET) begin
			calm = (sent >= 700 && sent < 900);
			if (!drained && sent >= 1100) begin
				drain();
				drained = 1'b1;
			end
			send_random_line();
		end
		calm = 1'b0;
		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/yls_pkg.sv
rtl/core/yls_in_stage.sv
rtl/core/yls_parser.sv
rtl/core/yls_out_stage.sv
rtl/core/yaml_line_splitter.sv
tb/sv/yls_checker.sv
tb/sv/tb_top.sv
